// ===== rtl/alu_8080_flags_unit_defines.svh =====
// ----------------------------------------------------------------------------
// alu_8080_flags_unit_defines
// assertion macros shared by the flags unit rtl
// ----------------------------------------------------------------------------
`ifndef ALU_8080_FLAGS_UNIT_DEFINES_SVH
`define ALU_8080_FLAGS_UNIT_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define ALU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/alu8080_pkg.sv =====
// ----------------------------------------------------------------------------
// alu8080_pkg
// operation codes, flag bundle and constants of the 8080 flags unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alu8080_pkg;

  // operation codes carried on the kind field
  typedef enum logic [3:0] {
    KIND_ADD = 4'd0,
    KIND_SUB = 4'd1,
    KIND_AND = 4'd2,
    KIND_XOR = 4'd3,
    KIND_OR  = 4'd4,
    KIND_CMP = 4'd5,
    KIND_INR = 4'd6,
    KIND_DCR = 4'd7,
    KIND_RLC = 4'd8,
    KIND_RRC = 4'd9,
    KIND_RAL = 4'd10,
    KIND_RAR = 4'd11,
    KIND_DAA = 4'd12,
    KIND_DAD = 4'd13
  } kind_t;

  // the five condition flags
  typedef struct packed {
    logic zero;
    logic sign;
    logic parity;
    logic carry;
    logic aux_carry;
  } flags_t;

  // decimal adjust corrections and nibble limits
  localparam logic [7:0] DAA_LO_FIX = 8'h06;
  localparam logic [7:0] DAA_HI_FIX = 8'h60;
  localparam logic [3:0] BCD_MAX    = 4'd9;
  localparam logic [3:0] NIBBLE_MAX = 4'hF;

endpackage

`default_nettype wire

// ===== rtl/alu8080_core.sv =====
// ----------------------------------------------------------------------------
// alu8080_core
// combinational 8080 datapath: arithmetic, logic, rotates, daa, dad and flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alu8080_core
  import alu8080_pkg::*;
(
  input  wire logic [3:0]  kind,
  input  wire logic [7:0]  acc,
  input  wire logic [7:0]  operand,
  input  wire logic        carry_operand,
  input  wire logic [15:0] hl,
  input  wire logic [15:0] pair,
  input  wire flags_t      flags_in,
  output logic [7:0]       acc_res,
  output logic [7:0]       reg_res,
  output logic [15:0]      hl_res,
  output flags_t           flags_res
);

  logic [8:0]  add_sum;
  logic [8:0]  sub_sum;
  logic [8:0]  cmp_diff;
  logic [7:0]  inr_val;
  logic [7:0]  dcr_val;
  logic [16:0] dad_sum;
  logic [3:0]  lo_nib;
  logic [3:0]  hi_nib;
  logic        daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_corr;
  logic [7:0]  daa_sum;
  logic [7:0]  res;
  logic        zsp;

  // adders of the arithmetic group
  assign add_sum  = {1'b0, acc} + {1'b0, operand} + {8'd0, carry_operand};
  assign sub_sum  = {1'b0, acc} + {1'b0, ~operand} + {8'd0, ~carry_operand};
  assign cmp_diff = {1'b0, acc} - {1'b0, operand};
  assign inr_val  = operand + 8'd1;
  assign dcr_val  = operand - 8'd1;
  assign dad_sum  = {1'b0, hl} + {1'b0, pair};

  // decimal adjust correction
  assign lo_nib   = acc[3:0];
  assign hi_nib   = acc[7:4];
  assign daa_lo   = (lo_nib > BCD_MAX) || flags_in.aux_carry;
  assign daa_hi   = (hi_nib > BCD_MAX) || flags_in.carry
                    || (daa_lo && (lo_nib > BCD_MAX) && (hi_nib >= BCD_MAX));
  assign daa_corr = (daa_lo ? DAA_LO_FIX : 8'h00) | (daa_hi ? DAA_HI_FIX : 8'h00);
  assign daa_sum  = acc + daa_corr;

  // operation select
  always_comb begin
    acc_res   = acc;
    reg_res   = operand;
    hl_res    = hl;
    flags_res = flags_in;
    res       = 8'h00;
    zsp       = 1'b0;
    case (kind)
      KIND_ADD: begin
        res                 = add_sum[7:0];
        acc_res             = res;
        flags_res.carry     = add_sum[8];
        flags_res.aux_carry = acc[4] ^ operand[4] ^ add_sum[4];
        zsp                 = 1'b1;
      end
      KIND_SUB: begin
        res                 = sub_sum[7:0];
        acc_res             = res;
        flags_res.carry     = ~sub_sum[8];
        flags_res.aux_carry = acc[4] ^ ~operand[4] ^ sub_sum[4];
        zsp                 = 1'b1;
      end
      KIND_AND: begin
        res                 = acc & operand;
        acc_res             = res;
        flags_res.carry     = 1'b0;
        flags_res.aux_carry = acc[3] | operand[3];
        zsp                 = 1'b1;
      end
      KIND_XOR: begin
        res                 = acc ^ operand;
        acc_res             = res;
        flags_res.carry     = 1'b0;
        flags_res.aux_carry = 1'b0;
        zsp                 = 1'b1;
      end
      KIND_OR: begin
        res                 = acc | operand;
        acc_res             = res;
        flags_res.carry     = 1'b0;
        flags_res.aux_carry = 1'b0;
        zsp                 = 1'b1;
      end
      KIND_CMP: begin
        res                 = cmp_diff[7:0];
        flags_res.carry     = cmp_diff[8];
        flags_res.aux_carry = ~(acc[4] ^ cmp_diff[4] ^ operand[4]);
        zsp                 = 1'b1;
      end
      KIND_INR: begin
        res                 = inr_val;
        reg_res             = inr_val;
        flags_res.aux_carry = (inr_val[3:0] == 4'h0);
        zsp                 = 1'b1;
      end
      KIND_DCR: begin
        res                 = dcr_val;
        reg_res             = dcr_val;
        flags_res.aux_carry = (dcr_val[3:0] != NIBBLE_MAX);
        zsp                 = 1'b1;
      end
      KIND_RLC: begin
        acc_res         = {acc[6:0], acc[7]};
        flags_res.carry = acc[7];
      end
      KIND_RRC: begin
        acc_res         = {acc[0], acc[7:1]};
        flags_res.carry = acc[0];
      end
      KIND_RAL: begin
        acc_res         = {acc[6:0], flags_in.carry};
        flags_res.carry = acc[7];
      end
      KIND_RAR: begin
        acc_res         = {flags_in.carry, acc[7:1]};
        flags_res.carry = acc[0];
      end
      KIND_DAA: begin
        res                 = daa_sum;
        acc_res             = daa_sum;
        flags_res.carry     = flags_in.carry | daa_hi;
        flags_res.aux_carry = acc[4] ^ daa_corr[4] ^ daa_sum[4];
        zsp                 = 1'b1;
      end
      KIND_DAD: begin
        hl_res          = dad_sum[15:0];
        flags_res.carry = dad_sum[16];
      end
      default: begin
        // unused codes pass everything through
        zsp = 1'b0;
      end
    endcase

    // zero, sign and parity from the 8-bit result, where the operation sets them
    if (zsp) begin
      flags_res.zero   = (res == 8'h00);
      flags_res.sign   = res[7];
      flags_res.parity = ~(^res);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/alu_8080_flags_unit.sv =====
// ----------------------------------------------------------------------------
// alu_8080_flags_unit
// 8080-style alu with flags, registered at input and result
// ----------------------------------------------------------------------------
// channel   signals                                   handshake
// input     kind .. aux_carry_in                      start & !busy
// result    acc_out .. aux_carry_out                  done, one cycle
//
// one item may be accepted every cycle; busy is held low
// a result passes through the input register, then the
// combinational core, then the result register
// synchronous reset clears the input valid and the done strobe
// the receiver cannot stall, so results are never held back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "alu_8080_flags_unit_defines.svh"

module alu_8080_flags_unit
  import alu8080_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  kind,
  input  wire logic [7:0]  accumulator,
  input  wire logic [7:0]  operand,
  input  wire logic        carry_operand,
  input  wire logic [15:0] hl_pair,
  input  wire logic [15:0] pair_operand,
  input  wire logic        zero_in,
  input  wire logic        sign_in,
  input  wire logic        parity_in,
  input  wire logic        carry_in,
  input  wire logic        aux_carry_in,
  output logic             done,
  output logic [7:0]       acc_out,
  output logic [7:0]       reg_out,
  output logic [15:0]      hl_out,
  output logic             zero_out,
  output logic             sign_out,
  output logic             parity_out,
  output logic             carry_out,
  output logic             aux_carry_out
);

  logic        in_valid;
  logic [3:0]  in_kind;
  logic [7:0]  in_acc;
  logic [7:0]  in_operand;
  logic        in_cop;
  logic [15:0] in_hl;
  logic [15:0] in_pair;
  flags_t      in_flags;

  logic [7:0]  acc_res;
  logic [7:0]  reg_res;
  logic [15:0] hl_res;
  flags_t      flags_res;
  flags_t      flags_q;

  logic        in_keeps_acc;
  logic        in_keeps_reg;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_kind    <= kind;
      in_acc     <= accumulator;
      in_operand <= operand;
      in_cop     <= carry_operand;
      in_hl      <= hl_pair;
      in_pair    <= pair_operand;
      in_flags   <= '{zero: zero_in, sign: sign_in, parity: parity_in,
                      carry: carry_in, aux_carry: aux_carry_in};
    end
  end

  // datapath
  alu8080_core u_core (
    .kind          (in_kind),
    .acc           (in_acc),
    .operand       (in_operand),
    .carry_operand (in_cop),
    .hl            (in_hl),
    .pair          (in_pair),
    .flags_in      (in_flags),
    .acc_res       (acc_res),
    .reg_res       (reg_res),
    .hl_res        (hl_res),
    .flags_res     (flags_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      acc_out <= acc_res;
      reg_out <= reg_res;
      hl_out  <= hl_res;
      flags_q <= flags_res;
    end
  end

  assign zero_out      = flags_q.zero;
  assign sign_out      = flags_q.sign;
  assign parity_out    = flags_q.parity;
  assign carry_out     = flags_q.carry;
  assign aux_carry_out = flags_q.aux_carry;

  // operations that leave the accumulator or the register operand alone
  assign in_keeps_acc = in_kind inside {KIND_CMP, KIND_INR, KIND_DCR, KIND_DAD};
  assign in_keeps_reg = !(in_kind inside {KIND_INR, KIND_DCR});

  // every accepted item yields a done strobe, through the input and result registers
  `ALU_ASSERT_NEXT(a_item_done, start && !busy, ##1 done, "accepted item lost its result")
  // a done strobe only follows an item in the input register
  `ALU_ASSERT_ALWAYS(a_done_src, !done || $past(in_valid), "done without an item")
  // cmp, inr, dcr and dad leave the accumulator alone
  `ALU_ASSERT_NEXT(a_acc_hold, in_valid && in_keeps_acc, acc_out == $past(in_acc), "acc changed")
  // only inr and dcr touch the register operand
  `ALU_ASSERT_NEXT(a_reg_hold, in_valid && in_keeps_reg, reg_out == $past(in_operand), "reg changed")

endmodule

`default_nettype wire
